### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, skipped while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, skipped while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### src/masi_pkg.sv
package masi_pkg;

   localparam int FIELD_MOTORS     = 4;
   localparam int DELTA_FIELD_BITS = 16;
   localparam int LEFT_BITS        = 15;
   localparam int MASK_BITS        = 4;
   localparam int ENABLE_BITS      = 3;

   localparam logic       OP_LOAD     = 1'b0;
   localparam logic       OP_TICK     = 1'b1;
   localparam logic [1:0] SECTION_0   = 2'd0;
   localparam logic [1:0] SECTION_1   = 2'd1;
   localparam logic [1:0] SECTION_2   = 2'd2;
   localparam logic [1:0] SECTION_ALL = 2'd3;
   localparam logic [ENABLE_BITS-1:0] ENABLE_OFF = 3'b111;
   localparam logic [LEFT_BITS-1:0]   LEFT_MAX   = 15'h7FFF;

   typedef struct packed {
      logic                               opcode;
      logic [1:0]                         section;
      logic signed [DELTA_FIELD_BITS-1:0] delta_0;
      logic signed [DELTA_FIELD_BITS-1:0] delta_1;
      logic signed [DELTA_FIELD_BITS-1:0] delta_2;
      logic signed [DELTA_FIELD_BITS-1:0] delta_3;
   } req_type;

   typedef struct packed {
      logic [MASK_BITS-1:0]   step_mask;
      logic [MASK_BITS-1:0]   dir_mask;
      logic [ENABLE_BITS-1:0] enable_n;
      logic [LEFT_BITS-1:0]   steps_left;
      logic                   busy_res;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic tick;
   } lane_ctl_type;

   typedef struct packed {
      logic step;
      logic neg;
   } lane_out_type;

   function automatic logic [ENABLE_BITS-1:0] section_enables(input logic [1:0] sec);
      logic [ENABLE_BITS-1:0] en;
      case (sec)
         SECTION_0: en = 3'b110;
         SECTION_1: en = 3'b101;
         SECTION_2: en = 3'b011;
         default:   en = 3'b000;
      endcase
      return en;
   endfunction

endpackage

### src/masi_lane.sv
module masi_lane #(
   parameter int DELTA_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  masi_pkg::lane_ctl_type      ctl,
   input  logic [DELTA_BITS-1:0]       raw_delta,
   input  logic [DELTA_BITS-2:0]       total,
   output logic [DELTA_BITS-2:0]       mag,
   output masi_pkg::lane_out_type      res
);

   localparam logic [DELTA_BITS-1:0] MOST_NEG = {1'b1, {(DELTA_BITS-1){1'b0}}};

   logic signed [DELTA_BITS-1:0] delta_sat;
   logic signed [DELTA_BITS-1:0] delta_ff, delta_in;
   logic [DELTA_BITS-2:0]        acc_ff, acc_in;
   logic [DELTA_BITS:0]          sum;
   logic [DELTA_BITS:0]          total_x;
   logic                         over, under;

   // Clamp the most negative code so its magnitude fits the step count.
   always_comb begin
      if (raw_delta == MOST_NEG) begin
         delta_sat = signed'(MOST_NEG + DELTA_BITS'(1));
      end else begin
         delta_sat = signed'(raw_delta);
      end
   end

   always_comb begin
      logic [DELTA_BITS-1:0] abs_v;
      abs_v = delta_sat[DELTA_BITS-1] ? DELTA_BITS'(-delta_sat) : DELTA_BITS'(delta_sat);
      mag   = abs_v[DELTA_BITS-2:0];
   end

   // Accumulator stays in [0, N); one add, then wrap by N either way.
   assign total_x = {2'b00, total};
   assign sum     = {2'b00, acc_ff} + {delta_ff[DELTA_BITS-1], delta_ff};
   assign under   = sum[DELTA_BITS];
   assign over    = !under && (sum >= total_x);

   always_comb begin
      logic [DELTA_BITS:0] wrapped;
      if (over) begin
         wrapped = sum - total_x;
      end else if (under) begin
         wrapped = sum + total_x;
      end else begin
         wrapped = sum;
      end
      acc_in   = acc_ff;
      delta_in = delta_ff;
      if (ctl.load) begin
         acc_in   = '0;
         delta_in = delta_sat;
      end else if (ctl.tick) begin
         acc_in = wrapped[DELTA_BITS-2:0];
      end
   end

   assign res.step = over || under;
   assign res.neg  = under;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         delta_ff <= '0;
      end else begin
         acc_ff   <= acc_in;
         delta_ff <= delta_in;
      end
   end

endmodule

### src/multi_axis_step_interpolator.sv
// An accepted request beat passes the input register and then the result register.
// Throughput: one item per cycle while rsp_stall does not hold a full result register.
// Backpressure on rsp_stall reaches req_stall only once both registers hold a beat.
// Reset (synchronous, active high) empties both registers and clears the move, the
// accumulators, the section and reverse_mask; csr_ready is always high.
module multi_axis_step_interpolator #(
   parameter int NUM_MOTORS = 4,
   parameter int DELTA_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  masi_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output masi_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [masi_pkg::MASK_BITS-1:0]        csr_data
);

   localparam int FIELD_W = (DELTA_BITS < masi_pkg::DELTA_FIELD_BITS) ?
                            DELTA_BITS : masi_pkg::DELTA_FIELD_BITS;
   localparam int CNT_W   = DELTA_BITS - 1;

   logic                   in_valid_ff, in_valid_in;
   masi_pkg::req_type      in_data_ff, in_data_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   masi_pkg::rsp_type      rsp_data_ff, rsp_data_in;
   logic [masi_pkg::MASK_BITS-1:0] reverse_ff, reverse_in;
   logic [CNT_W-1:0]       total_ff, total_in;
   logic [CNT_W-1:0]       remaining_ff, remaining_in;
   logic [1:0]             section_ff, section_in;

   logic                   accept_in, advance, is_load, is_tick;
   logic [CNT_W-1:0]       n_max;
   logic [masi_pkg::LEFT_BITS-1:0] steps_left_w;
   logic [masi_pkg::MASK_BITS-1:0] step_w, dir_w;
   masi_pkg::lane_ctl_type lane_ctl;

   logic [masi_pkg::DELTA_FIELD_BITS-1:0] field_u [masi_pkg::FIELD_MOTORS];
   logic [DELTA_BITS-1:0]  raw_w [NUM_MOTORS];
   logic [CNT_W-1:0]       mag_w [NUM_MOTORS];
   masi_pkg::lane_out_type lane_res [NUM_MOTORS];

   // Handshake: the item in the input register moves on when the result slot frees.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept_in = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign is_load = advance && (in_data_ff.opcode == masi_pkg::OP_LOAD);
   assign is_tick = advance && (in_data_ff.opcode == masi_pkg::OP_TICK) && (remaining_ff != '0);
   assign lane_ctl.load = is_load;
   assign lane_ctl.tick = is_tick;

   assign field_u[0] = in_data_ff.delta_0;
   assign field_u[1] = in_data_ff.delta_1;
   assign field_u[2] = in_data_ff.delta_2;
   assign field_u[3] = in_data_ff.delta_3;

   for (genvar i = 0; i < NUM_MOTORS; i++) begin : g_lane
      if (i < masi_pkg::FIELD_MOTORS) begin : g_field
         assign raw_w[i] = DELTA_BITS'(field_u[i][FIELD_W-1:0]);
      end else begin : g_nofield
         assign raw_w[i] = '0;
      end
      masi_lane #(
         .DELTA_BITS (DELTA_BITS)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctl       (lane_ctl),
         .raw_delta (raw_w[i]),
         .total     (total_ff),
         .mag       (mag_w[i]),
         .res       (lane_res[i])
      );
   end

   always_comb begin
      n_max = '0;
      for (int i = 0; i < NUM_MOTORS; i++) begin
         if (mag_w[i] > n_max) begin
            n_max = mag_w[i];
         end
      end
   end

   for (genvar j = 0; j < masi_pkg::MASK_BITS; j++) begin : g_bits
      if (j < NUM_MOTORS) begin : g_used
         assign step_w[j] = is_tick && lane_res[j].step;
         assign dir_w[j]  = is_tick && (reverse_ff[j] ? lane_res[j].neg : !lane_res[j].neg);
      end else begin : g_unused
         assign step_w[j] = 1'b0;
         assign dir_w[j]  = 1'b0;
      end
   end

   always_comb begin
      total_in     = total_ff;
      remaining_in = remaining_ff;
      section_in   = section_ff;
      if (is_load) begin
         total_in     = n_max;
         remaining_in = n_max;
         section_in   = in_data_ff.section;
      end else if (is_tick) begin
         remaining_in = remaining_ff - CNT_W'(1);
      end
   end

   // Saturate the count only when it is wider than the result field.
   if (CNT_W > masi_pkg::LEFT_BITS) begin : g_sat
      assign steps_left_w = (|remaining_in[CNT_W-1:masi_pkg::LEFT_BITS]) ?
                            masi_pkg::LEFT_MAX : remaining_in[masi_pkg::LEFT_BITS-1:0];
   end else begin : g_nosat
      assign steps_left_w = masi_pkg::LEFT_BITS'(remaining_in);
   end

   always_comb begin
      rsp_data_in.step_mask  = step_w;
      rsp_data_in.dir_mask   = dir_w;
      rsp_data_in.enable_n   = is_tick ? masi_pkg::section_enables(section_ff)
                                       : masi_pkg::ENABLE_OFF;
      rsp_data_in.steps_left = steps_left_w;
      rsp_data_in.busy_res   = (remaining_in != '0);
   end

   always_comb begin
      in_data_in  = accept_in ? req_data : in_data_ff;
      in_valid_in = accept_in || (in_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
      reverse_in  = csr_valid ? csr_data : reverse_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         reverse_ff   <= '0;
         total_ff     <= '0;
         remaining_ff <= '0;
         section_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         reverse_ff   <= reverse_in;
         total_ff     <= total_in;
         remaining_ff <= remaining_in;
         section_ff   <= section_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### src/masi_checker.sv
`include "assert_macros.svh"

module masi_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input masi_pkg::rsp_type rsp_data
);

   logic stalled, busy_ok, sections_off, rsp_quiet;

   assign stalled      = rsp_valid && rsp_stall;
   assign busy_ok      = rsp_data.busy_res == (rsp_data.steps_left != '0);
   assign sections_off = rsp_valid && (rsp_data.enable_n == masi_pkg::ENABLE_OFF);
   assign rsp_quiet    = (rsp_data.step_mask == '0) && (rsp_data.dir_mask == '0);

   // Hold a stalled result beat.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_valid && $stable(rsp_data))

   `ASSERT_IMPLY(a_busy_left, clock, reset, rsp_valid, busy_ok)

   // With all sections off, no motor may step and direction is idle.
   `ASSERT_IMPLY(a_idle_quiet, clock, reset, sections_off, rsp_quiet)

   `ASSERT_IMPLY(a_reset_empty, clock, reset, $past(reset), !rsp_valid && !req_stall)

endmodule

bind multi_axis_step_interpolator masi_checker u_masi_checker (.*);

### tb/sv/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   masi_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   masi_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [masi_pkg::MASK_BITS-1:0] csr_data = '0;

   // interpolator state as predicted from accepted beats
   int                motor_delta [masi_pkg::FIELD_MOTORS];
   int                motor_acc [masi_pkg::FIELD_MOTORS];
   int                move_len;
   int                ticks_left;
   logic [1:0]        move_section;
   logic [masi_pkg::MASK_BITS-1:0] dir_invert;

   masi_pkg::rsp_type pending_steps [$];
   int                mismatch_count = 0;
   int                send_idle_pct = 0;
   int                rsp_stall_pct = 0;

   multi_axis_step_interpolator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   function automatic int delta_of(masi_pkg::req_type beat, int m);
      logic signed [masi_pkg::DELTA_FIELD_BITS-1:0] raw;
      case (m)
         0: raw = beat.delta_0;
         1: raw = beat.delta_1;
         2: raw = beat.delta_2;
         default: raw = beat.delta_3;
      endcase
      return int'(raw);
   endfunction

   // Advance the predicted interpolator by one beat and return its step output.
   function automatic masi_pkg::rsp_type advance_interpolator(masi_pkg::req_type beat);
      masi_pkg::rsp_type out;
      int      d;
      int      acc;
      out = '0;
      out.enable_n = masi_pkg::ENABLE_OFF;
      if (beat.opcode == masi_pkg::OP_LOAD) begin
         move_len = 0;
         for (int m = 0; m < masi_pkg::FIELD_MOTORS; m++) begin
            d = delta_of(beat, m);
            // most negative code has no positive twin; clamp it
            if (d < -32767) d = -32767;
            motor_delta[m] = d;
            motor_acc[m] = 0;
            if (d < 0) d = -d;
            if (d > move_len) move_len = d;
         end
         ticks_left = move_len;
         move_section = beat.section;
      end else if (ticks_left > 0) begin
         for (int m = 0; m < masi_pkg::FIELD_MOTORS; m++) begin
            acc = motor_acc[m] + motor_delta[m];
            if (acc >= move_len) begin
               acc -= move_len;
               out.step_mask[m] = 1'b1;
               out.dir_mask[m] = !dir_invert[m];
            end else if (acc < 0) begin
               acc += move_len;
               out.step_mask[m] = 1'b1;
               out.dir_mask[m] = dir_invert[m];
            end else begin
               out.dir_mask[m] = !dir_invert[m];
            end
            motor_acc[m] = acc;
         end
         ticks_left--;
         out.enable_n = (move_section == masi_pkg::SECTION_ALL) ? '0
                                                                : ~(3'b001 << move_section);
      end
      out.steps_left = ticks_left[masi_pkg::LEFT_BITS-1:0];
      out.busy_res = (ticks_left > 0);
      return out;
   endfunction

   function automatic void check_field(string field, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      masi_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_steps.size() == 0) begin
            $error("result beat with no step output pending");
            mismatch_count++;
         end else begin
            want = pending_steps.pop_front();
            check_field("step_mask", want.step_mask, rsp_data.step_mask);
            check_field("dir_mask", want.dir_mask, rsp_data.dir_mask);
            check_field("enable_n", want.enable_n, rsp_data.enable_n);
            check_field("steps_left", want.steps_left, rsp_data.steps_left);
            check_field("busy_res", want.busy_res, rsp_data.busy_res);
         end
      end
   end

   // Offer one beat, idling first at the sender's rate; leaves valid high.
   task automatic drive_command(masi_pkg::req_type beat);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (req_stall);
      pending_steps.push_back(advance_interpolator(beat));
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pending_steps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reverse_mask(logic [masi_pkg::MASK_BITS-1:0] mask);
      drain_pipeline();
      csr_valid <= 1'b1;
      csr_data <= mask;
      do @(posedge clock); while (!csr_ready);
      dir_invert = mask;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic masi_pkg::req_type make_load(logic [1:0] sec, int d0, int d1,
                                                    int d2, int d3);
      masi_pkg::req_type beat;
      beat.opcode = masi_pkg::OP_LOAD;
      beat.section = sec;
      beat.delta_0 = d0[masi_pkg::DELTA_FIELD_BITS-1:0];
      beat.delta_1 = d1[masi_pkg::DELTA_FIELD_BITS-1:0];
      beat.delta_2 = d2[masi_pkg::DELTA_FIELD_BITS-1:0];
      beat.delta_3 = d3[masi_pkg::DELTA_FIELD_BITS-1:0];
      return beat;
   endfunction

   function automatic masi_pkg::req_type make_tick();
      masi_pkg::req_type beat;
      beat = make_load(masi_pkg::SECTION_0, 0, 0, 0, 0);
      beat.opcode = masi_pkg::OP_TICK;
      return beat;
   endfunction

   task automatic run_ticks(int count);
      repeat (count) drive_command(make_tick());
   endtask

   function automatic int pick_delta();
      int r;
      r = int'($urandom_range(15));
      if (r == 0) return int'($signed(16'($urandom())));
      if (r == 1) begin
         case ($urandom_range(4))
            0: return -32768;
            1: return 32767;
            2: return -32767;
            3: return 1;
            default: return -1;
         endcase
      end
      return int'($urandom_range(40)) - 20;
   endfunction

   function automatic masi_pkg::req_type random_beat();
      masi_pkg::req_type beat;
      beat.opcode = 1'($urandom_range(1));
      beat.section = 2'($urandom_range(3));
      beat.delta_0 = 16'($urandom());
      beat.delta_1 = 16'($urandom());
      beat.delta_2 = 16'($urandom());
      beat.delta_3 = 16'($urandom());
      return beat;
   endfunction

   task automatic test_idle_tick();
      write_reverse_mask(4'h0);
      drive_command(make_tick());
      drain_pipeline();
   endtask

   task automatic test_short_move();
      drive_command(make_load(masi_pkg::SECTION_0, 3, -2, 0, 1));
      run_ticks(4);
      drive_command(make_load(masi_pkg::SECTION_2, 5, 5, -5, -5));
      run_ticks(5);
      drain_pipeline();
   endtask

   task automatic test_delta_extremes();
      drive_command(make_load(masi_pkg::SECTION_ALL, -32768, 32767, 1, -1));
      run_ticks(2);
      // zero-length move: load reports idle, tick does nothing
      drive_command(make_load(masi_pkg::SECTION_1, 0, 0, 0, 0));
      run_ticks(1);
      drain_pipeline();
   endtask

   task automatic test_reverse_sense();
      write_reverse_mask(4'hF);
      drive_command(make_load(masi_pkg::SECTION_1, 2, -3, 1, 0));
      run_ticks(4);
      write_reverse_mask(4'h5);
      drive_command(make_load(masi_pkg::SECTION_ALL, -2, 2, 0, -1));
      run_ticks(2);
      drain_pipeline();
   endtask

   task automatic test_random_moves(int budget, int idle_pct, int stall_pct,
                                    logic [masi_pkg::MASK_BITS-1:0] mask);
      int     issued;
      int     ticks;
      masi_pkg::req_type beat;
      write_reverse_mask(mask);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      issued = 0;
      while (issued < budget) begin
         if ($urandom_range(9) == 0) begin
            drive_command(random_beat());
            issued++;
         end else begin
            beat = make_load(2'($urandom_range(3)), pick_delta(), pick_delta(),
                             pick_delta(), pick_delta());
            drive_command(beat);
            issued++;
            // run long moves only partway, then cut them off with a new load
            if (move_len <= 48) ticks = move_len + int'($urandom_range(2));
            else ticks = int'($urandom_range(1, 48));
            repeat (ticks) begin
               beat = random_beat();
               beat.opcode = masi_pkg::OP_TICK;
               drive_command(beat);
               issued++;
            end
         end
      end
      drain_pipeline();
   endtask

   initial begin
      for (int m = 0; m < masi_pkg::FIELD_MOTORS; m++) begin
         motor_delta[m] = 0;
         motor_acc[m] = 0;
      end
      move_len = 0;
      ticks_left = 0;
      move_section = masi_pkg::SECTION_0;
      dir_invert = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_tick();
      test_short_move();
      test_delta_extremes();
      test_reverse_sense();
      test_random_moves(460, 12, 45, 4'($urandom()));
      test_random_moves(460, 45, 12, 4'hA);
      test_random_moves(460, 0, 0, 4'($urandom()));

      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+src
src/masi_pkg.sv
src/masi_lane.sv
src/multi_axis_step_interpolator.sv
src/masi_checker.sv
tb/sv/tb.sv
